>>> design/point_triangle_penalty_collision_macros.svh
// Assertion macros shared by the point-triangle collision checker.
`ifndef POINT_TRIANGLE_PENALTY_COLLISION_MACROS_SVH
`define POINT_TRIANGLE_PENALTY_COLLISION_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define PTPC_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("ptpc assertion failed");

// Clocked assertion that also holds across reset.
`define PTPC_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("ptpc assertion failed");

`endif

>>> design/ptpc_pkg.sv
// Shared widths, codes and types of the point-triangle collision block.
`default_nettype none

package ptpc_pkg;

  localparam int COORD_W = 16;
  localparam int SLOT_W  = 10;
  localparam int EPS_W   = 53;
  localparam int CNT_W   = 9;
  localparam int IDX_W   = 8;
  localparam int DEPTH_W = 54;
  localparam int FORCE_W = 64;
  localparam int CFG_IDX_W = 1;

  localparam logic [EPS_W-1:0] EPS_RESET = 53'd20480;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_EPSILON   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TRI_COUNT = 1'b1;

  // Item actions
  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  // Command passed from the front end to the scan engine
  typedef struct packed {
    logic                      is_query;
    logic [SLOT_W-1:0]         slot;
    logic signed [COORD_W-1:0] z;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] x;
  } cmd_t;

endpackage

`default_nettype wire

>>> design/ptpc_ifs.sv
// Input and result channel interfaces of the point-triangle collision block.
`default_nettype none

interface ptpc_in_if;
  logic                                        valid;
  logic                                        ready;
  logic                                        action;
  logic [ptpc_pkg::SLOT_W-1:0]                 vertex_index;
  logic signed [ptpc_pkg::COORD_W-1:0]         coord_x;
  logic signed [ptpc_pkg::COORD_W-1:0]         coord_y;
  logic signed [ptpc_pkg::COORD_W-1:0]         coord_z;

  modport source (output valid, action, vertex_index, coord_x, coord_y, coord_z,
                  input ready);
  modport sink   (input valid, action, vertex_index, coord_x, coord_y, coord_z,
                  output ready);
endinterface

interface ptpc_out_if;
  logic                                valid;
  logic                                ready;
  logic                                hit;
  logic [ptpc_pkg::IDX_W-1:0]          triangle_index;
  logic signed [ptpc_pkg::DEPTH_W-1:0] depth;
  logic signed [ptpc_pkg::FORCE_W-1:0] force_x;
  logic signed [ptpc_pkg::FORCE_W-1:0] force_y;
  logic signed [ptpc_pkg::FORCE_W-1:0] force_z;

  modport source (output valid, hit, triangle_index, depth, force_x, force_y, force_z,
                  input ready);
  modport sink   (input valid, hit, triangle_index, depth, force_x, force_y, force_z,
                  output ready);
endinterface

`default_nettype wire

>>> design/ptpc_front.sv
// Front end: accepts items, drops out-of-range loads, queues commands.
`default_nettype none

module ptpc_front #(
  parameter int MAX_TRIANGLES = 256
) (
  input  wire logic      clk,
  input  wire logic      rst,
  ptpc_in_if.sink        req,
  output ptpc_pkg::cmd_t cmd,
  output logic           cmd_valid,
  input  wire logic      cmd_ready
);

  localparam int SLOTS = 3 * MAX_TRIANGLES;

  ptpc_pkg::cmd_t q [2];
  ptpc_pkg::cmd_t entry;
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] used;
  logic       is_query;
  logic       slot_ok;
  logic       push;
  logic       pop;

  // Classify the item
  assign is_query = (req.action == ptpc_pkg::ACT_QUERY);
  assign slot_ok  = int'(req.vertex_index) < SLOTS;

  assign entry.is_query = is_query;
  assign entry.slot     = req.vertex_index;
  assign entry.x        = req.coord_x;
  assign entry.y        = req.coord_y;
  assign entry.z        = req.coord_z;

  // Two-entry queue toward the scan engine
  assign req.ready = (used != 2'd2);
  assign push      = req.valid && req.ready && (is_query || slot_ok);
  assign pop       = cmd_valid && cmd_ready;
  assign cmd_valid = (used != 2'd0);
  assign cmd       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      used   <= 2'd0;
    end else begin
      if (push) begin
        q[wr_ptr] <= entry;
        wr_ptr    <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      used <= 2'(used + {1'b0, push} - {1'b0, pop});
    end
  end

endmodule

`default_nettype wire

>>> design/ptpc_back.sv
// Back end: vertex store, config registers, triangle scan and result register.
`default_nettype none

module ptpc_back #(
  parameter int MAX_TRIANGLES = 256
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [ptpc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [ptpc_pkg::EPS_W-1:0]       cfg_data,
  input  wire ptpc_pkg::cmd_t                   cmd,
  input  wire logic                             cmd_valid,
  output logic                                  cmd_ready,
  ptpc_out_if.source                            rsp
);

  localparam int SLOTS = 3 * MAX_TRIANGLES;
  localparam int AW    = $clog2(SLOTS);
  localparam int TW    = $clog2(MAX_TRIANGLES + 1);
  localparam int CW    = (TW > ptpc_pkg::CNT_W) ? TW : ptpc_pkg::CNT_W;
  localparam logic [CW-1:0] MAX_CW = CW'(MAX_TRIANGLES);
  localparam int ACC_W = 91;
  localparam int WIDE_W = 72;
  localparam int FSHIFT = 27;

  // Sequencer steps with a special meaning
  localparam logic [5:0] STEP_D_CHECK = 6'd10;
  localparam logic [5:0] STEP_B_CHECK = 6'd33;
  localparam logic [5:0] STEP_DONE    = 6'd41;

  typedef enum logic [1:0] {S_IDLE, S_FETCH, S_CALC, S_DONE} state_t;
  typedef enum logic [1:0] {OP_LOAD, OP_ADD, OP_SUB, OP_SHADD} op_t;
  typedef enum logic [3:0] {
    DST_NONE, DST_N0, DST_N1, DST_N2, DST_D, DST_DEN, DST_T0, DST_T1, DST_T2,
    DST_NU, DST_NV, DST_F0, DST_F1, DST_F2
  } dst_t;

  state_t state;

  // Configuration
  logic [ptpc_pkg::EPS_W-1:0] eps;
  logic [ptpc_pkg::CNT_W-1:0] tcount;
  logic [CW-1:0]              limit;

  // Vertex store
  logic [3*ptpc_pkg::COORD_W-1:0] mem [SLOTS];
  logic [3*ptpc_pkg::COORD_W-1:0] rdata;
  logic                           mem_we;
  logic                           mem_re;
  logic [AW-1:0]                  raddr;

  // Scan state
  logic [3*ptpc_pkg::COORD_W-1:0] pq, va, vb, vc;
  logic [CW-1:0]  tri_n;
  logic [AW-1:0]  base;
  logic [1:0]     fcnt;
  logic [5:0]     step;
  logic           res_hit;

  // Datapath
  logic signed [16:0] e1 [3];
  logic signed [16:0] e2 [3];
  logic signed [16:0] pa [3];
  logic signed [34:0] n [3];
  logic signed [34:0] t [3];
  logic signed [ptpc_pkg::DEPTH_W-1:0] d;
  logic signed [WIDE_W-1:0] den, nu, nv;
  logic signed [WIDE_W+1:0] rest;
  logic signed [54:0] d_ext, eps_ext, f;
  logic signed [27:0] f_hi, f_lo;
  logic plane_ok, bary_ok;

  logic signed [35:0] m_a, m_b;
  logic               issue_step, issue;
  op_t                op;
  dst_t               dst;
  logic signed [71:0] prod;
  logic               p_vld;
  op_t                p_op;
  dst_t               p_dst;
  logic signed [ACC_W-1:0] acc, acc_next;
  logic signed [ptpc_pkg::FORCE_W-1:0] fx, fy, fz, sat;

  logic signed [ptpc_pkg::FORCE_W-1:0] o_fx, o_fy, o_fz;
  logic signed [ptpc_pkg::DEPTH_W-1:0] o_depth;
  logic [ptpc_pkg::IDX_W-1:0]          o_idx;
  logic                                o_hit, o_valid;

  assign cmd_ready = (state == S_IDLE);

  // Scan length clamped to the store size
  always_comb begin
    limit = CW'(tcount);
    if (limit > MAX_CW) begin
      limit = MAX_CW;
    end
  end

  // Store port control
  assign mem_we = (state == S_IDLE) && cmd_valid && !cmd.is_query;
  assign mem_re = (state == S_FETCH) && (fcnt != 2'd3);
  assign raddr  = AW'(base + AW'(fcnt));

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[AW'(cmd.slot)] <= {cmd.z, cmd.y, cmd.x};
    end
    if (mem_re) begin
      rdata <= mem[raddr];
    end
  end

  // Edge and point vectors
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      e1[k] = 17'(signed'(vb[16*k +: 16])) - 17'(signed'(va[16*k +: 16]));
      e2[k] = 17'(signed'(vc[16*k +: 16])) - 17'(signed'(va[16*k +: 16]));
      pa[k] = 17'(signed'(pq[16*k +: 16])) - 17'(signed'(va[16*k +: 16]));
    end
  end

  // Plane and barycentric tests
  assign d_ext    = 55'(d);
  assign eps_ext  = signed'({2'b00, eps});
  assign plane_ok = (d_ext <= eps_ext) && (d_ext >= -eps_ext);
  assign f        = eps_ext - d_ext;
  assign f_hi     = f[54:FSHIFT];
  assign f_lo     = signed'({1'b0, f[FSHIFT-1:0]});
  assign rest     = (WIDE_W+2)'(den) - (WIDE_W+2)'(nu) - (WIDE_W+2)'(nv);
  assign bary_ok  = (den > 0) && !nu[WIDE_W-1] && !nv[WIDE_W-1] && (rest > 0);

  // Operand schedule: one product per step
  always_comb begin
    m_a = '0;
    m_b = '0;
    op  = OP_LOAD;
    dst = DST_NONE;
    issue_step = 1'b1;
    unique case (step)
      6'd0:  begin m_a = 36'(e1[1]); m_b = 36'(e2[2]); end
      6'd1:  begin m_a = 36'(e1[2]); m_b = 36'(e2[1]); op = OP_SUB; dst = DST_N0; end
      6'd2:  begin m_a = 36'(e1[2]); m_b = 36'(e2[0]); end
      6'd3:  begin m_a = 36'(e1[0]); m_b = 36'(e2[2]); op = OP_SUB; dst = DST_N1; end
      6'd4:  begin m_a = 36'(e1[0]); m_b = 36'(e2[1]); end
      6'd5:  begin m_a = 36'(e1[1]); m_b = 36'(e2[0]); op = OP_SUB; dst = DST_N2; end
      6'd6:  begin m_a = 36'(n[0]); m_b = 36'(pa[0]); end
      6'd7:  begin m_a = 36'(n[1]); m_b = 36'(pa[1]); op = OP_ADD; end
      6'd8:  begin m_a = 36'(n[2]); m_b = 36'(pa[2]); op = OP_ADD; dst = DST_D; end
      6'd11: begin m_a = 36'(n[0]); m_b = 36'(n[0]); end
      6'd12: begin m_a = 36'(n[1]); m_b = 36'(n[1]); op = OP_ADD; end
      6'd13: begin m_a = 36'(n[2]); m_b = 36'(n[2]); op = OP_ADD; dst = DST_DEN; end
      6'd14: begin m_a = 36'(e1[1]); m_b = 36'(pa[2]); end
      6'd15: begin m_a = 36'(e1[2]); m_b = 36'(pa[1]); op = OP_SUB; dst = DST_T0; end
      6'd16: begin m_a = 36'(e1[2]); m_b = 36'(pa[0]); end
      6'd17: begin m_a = 36'(e1[0]); m_b = 36'(pa[2]); op = OP_SUB; dst = DST_T1; end
      6'd18: begin m_a = 36'(e1[0]); m_b = 36'(pa[1]); end
      6'd19: begin m_a = 36'(e1[1]); m_b = 36'(pa[0]); op = OP_SUB; dst = DST_T2; end
      6'd20: begin m_a = 36'(t[0]); m_b = 36'(n[0]); end
      6'd21: begin m_a = 36'(t[1]); m_b = 36'(n[1]); op = OP_ADD; end
      6'd22: begin m_a = 36'(t[2]); m_b = 36'(n[2]); op = OP_ADD; dst = DST_NU; end
      6'd23: begin m_a = 36'(pa[1]); m_b = 36'(e2[2]); end
      6'd24: begin m_a = 36'(pa[2]); m_b = 36'(e2[1]); op = OP_SUB; dst = DST_T0; end
      6'd25: begin m_a = 36'(pa[2]); m_b = 36'(e2[0]); end
      6'd26: begin m_a = 36'(pa[0]); m_b = 36'(e2[2]); op = OP_SUB; dst = DST_T1; end
      6'd27: begin m_a = 36'(pa[0]); m_b = 36'(e2[1]); end
      6'd28: begin m_a = 36'(pa[1]); m_b = 36'(e2[0]); op = OP_SUB; dst = DST_T2; end
      6'd29: begin m_a = 36'(t[0]); m_b = 36'(n[0]); end
      6'd30: begin m_a = 36'(t[1]); m_b = 36'(n[1]); op = OP_ADD; end
      6'd31: begin m_a = 36'(t[2]); m_b = 36'(n[2]); op = OP_ADD; dst = DST_NV; end
      6'd34: begin m_a = 36'(f_hi); m_b = 36'(n[0]); end
      6'd35: begin m_a = 36'(f_lo); m_b = 36'(n[0]); op = OP_SHADD; dst = DST_F0; end
      6'd36: begin m_a = 36'(f_hi); m_b = 36'(n[1]); end
      6'd37: begin m_a = 36'(f_lo); m_b = 36'(n[1]); op = OP_SHADD; dst = DST_F1; end
      6'd38: begin m_a = 36'(f_hi); m_b = 36'(n[2]); end
      6'd39: begin m_a = 36'(f_lo); m_b = 36'(n[2]); op = OP_SHADD; dst = DST_F2; end
      default: issue_step = 1'b0;
    endcase
  end

  assign issue = (state == S_CALC) && issue_step;

  // Accumulate stage
  always_comb begin
    unique case (p_op)
      OP_LOAD:  acc_next = ACC_W'(prod);
      OP_ADD:   acc_next = acc + ACC_W'(prod);
      OP_SUB:   acc_next = acc - ACC_W'(prod);
      OP_SHADD: acc_next = (acc <<< FSHIFT) + ACC_W'(prod);
      default:  acc_next = acc;
    endcase
  end

  // Saturate force to 64 bits
  always_comb begin
    if ((&acc_next[ACC_W-1:63]) || !(|acc_next[ACC_W-1:63])) begin
      sat = acc_next[63:0];
    end else if (acc_next[ACC_W-1]) begin
      sat = {1'b1, {(ptpc_pkg::FORCE_W-1){1'b0}}};
    end else begin
      sat = {1'b0, {(ptpc_pkg::FORCE_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_vld <= 1'b0;
    end else begin
      p_vld <= issue;
    end
  end

  // Multiply stage and result write-back
  always_ff @(posedge clk) begin
    prod  <= m_a * m_b;
    p_op  <= op;
    p_dst <= dst;
    if (p_vld) begin
      acc <= acc_next;
      unique case (p_dst)
        DST_N0:  n[0] <= acc_next[34:0];
        DST_N1:  n[1] <= acc_next[34:0];
        DST_N2:  n[2] <= acc_next[34:0];
        DST_D:   d    <= acc_next[ptpc_pkg::DEPTH_W-1:0];
        DST_DEN: den  <= acc_next[WIDE_W-1:0];
        DST_T0:  t[0] <= acc_next[34:0];
        DST_T1:  t[1] <= acc_next[34:0];
        DST_T2:  t[2] <= acc_next[34:0];
        DST_NU:  nu   <= acc_next[WIDE_W-1:0];
        DST_NV:  nv   <= acc_next[WIDE_W-1:0];
        DST_F0:  fx   <= sat;
        DST_F1:  fy   <= sat;
        DST_F2:  fz   <= sat;
        default: ;
      endcase
    end
  end

  // Control sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      o_valid <= 1'b0;
      eps     <= ptpc_pkg::EPS_RESET;
      tcount  <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          ptpc_pkg::CFG_EPSILON:   eps    <= cfg_data;
          ptpc_pkg::CFG_TRI_COUNT: tcount <= cfg_data[ptpc_pkg::CNT_W-1:0];
          default: ;
        endcase
      end
      if (rsp.ready) begin
        o_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd_valid && cmd.is_query) begin
            pq      <= {cmd.z, cmd.y, cmd.x};
            tri_n   <= '0;
            base    <= '0;
            fcnt    <= 2'd0;
            res_hit <= 1'b0;
            state   <= (limit == '0) ? S_DONE : S_FETCH;
          end
        end
        S_FETCH: begin
          fcnt <= 2'(fcnt + 2'd1);
          unique case (fcnt)
            2'd1:    va <= rdata;
            2'd2:    vb <= rdata;
            2'd3:    begin vc <= rdata; step <= '0; state <= S_CALC; end
            default: ;
          endcase
        end
        S_CALC: begin
          step <= 6'(step + 6'd1);
          if ((step == STEP_D_CHECK && !plane_ok) || (step == STEP_B_CHECK && !bary_ok)) begin
            if (CW'(tri_n + 1'b1) == limit) begin
              state <= S_DONE;
            end else begin
              tri_n <= CW'(tri_n + 1'b1);
              base  <= AW'(base + AW'(3));
              fcnt  <= 2'd0;
              state <= S_FETCH;
            end
          end else if (step == STEP_DONE) begin
            res_hit <= 1'b1;
            state   <= S_DONE;
          end
        end
        S_DONE: begin
          if (!o_valid || rsp.ready) begin
            o_valid <= 1'b1;
            o_hit   <= res_hit;
            o_idx   <= res_hit ? ptpc_pkg::IDX_W'(tri_n) : '0;
            o_depth <= res_hit ? d : '0;
            o_fx    <= res_hit ? fx : '0;
            o_fy    <= res_hit ? fy : '0;
            o_fz    <= res_hit ? fz : '0;
            state   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign rsp.valid          = o_valid;
  assign rsp.hit            = o_hit;
  assign rsp.triangle_index = o_idx;
  assign rsp.depth          = o_depth;
  assign rsp.force_x        = o_fx;
  assign rsp.force_y        = o_fy;
  assign rsp.force_z        = o_fz;

endmodule

`default_nettype wire

>>> design/point_triangle_penalty_collision.sv
// Top level of the point-triangle proximity and penalty force block.
// Usage:
//   req carries items: action 0 stores one vertex at vertex_index (triangle*3+corner),
//   action 1 queries the point (coord_x, coord_y, coord_z). Only queries answer on rsp.
//   Loads with a slot beyond the store are accepted and dropped.
//   cfg_we/cfg_index/cfg_data write epsilon (0) and triangle_count (1) while idle.
// Operation:
//   A load is written to the vertex store as the idle scan engine takes it. A query
//   scans triangles in order; for each it fetches the three corners from the store,
//   then steps to the plane test, the barycentric test and, on a hit, the force
//   products on the single shared 36x36 multiplier, one product per issuing step.
//   The first hit ends the scan; a query with a count of zero answers without scanning.
// Reset: rst is synchronous; it empties the queue and result register and restores
//   epsilon to 5.0 and triangle_count to 0. The vertex store is not cleared.
// Stall: a two-entry queue accepts items while the engine works until it is full;
//   a finished result waits in the output register until rsp.ready.
`default_nettype none

module point_triangle_penalty_collision #(
  parameter int MAX_TRIANGLES = 256
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [ptpc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ptpc_pkg::EPS_W-1:0]     cfg_data,
  ptpc_in_if.sink                             req,
  ptpc_out_if.source                          rsp
);

  ptpc_pkg::cmd_t cmd;
  logic           cmd_valid;
  logic           cmd_ready;

  // Item intake and queue
  ptpc_front #(.MAX_TRIANGLES(MAX_TRIANGLES)) u_front (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready)
  );

  // Vertex store and scan engine
  ptpc_back #(.MAX_TRIANGLES(MAX_TRIANGLES)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .rsp       (rsp)
  );

endmodule

`default_nettype wire

>>> design/ptpc_checker.sv
// Port-level checker of the point-triangle collision block and its bind.
`default_nettype none
`include "point_triangle_penalty_collision_macros.svh"

module ptpc_checker (
  input wire logic                                clk,
  input wire logic                                rst,
  input wire logic                                cfg_we,
  input wire logic [ptpc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input wire logic [ptpc_pkg::EPS_W-1:0]          cfg_data,
  input wire logic                                req_valid,
  input wire logic                                req_ready,
  input wire logic                                req_action,
  input wire logic                                rsp_valid,
  input wire logic                                rsp_ready,
  input wire logic                                rsp_hit,
  input wire logic [ptpc_pkg::IDX_W-1:0]          rsp_index,
  input wire logic signed [ptpc_pkg::DEPTH_W-1:0] rsp_depth,
  input wire logic signed [ptpc_pkg::FORCE_W-1:0] rsp_fx,
  input wire logic signed [ptpc_pkg::FORCE_W-1:0] rsp_fy,
  input wire logic signed [ptpc_pkg::FORCE_W-1:0] rsp_fz
);

  logic [2:0]                 pending;
  logic [ptpc_pkg::EPS_W-1:0] eps;
  logic                       q_in, r_out;
  logic signed [54:0]         dw, ew;
  logic                       depth_ok;
  logic                       miss_zero;

  assign q_in  = req_valid && req_ready && (req_action == ptpc_pkg::ACT_QUERY);
  assign r_out = rsp_valid && rsp_ready;

  // Queries in flight and current threshold
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 3'd0;
      eps     <= ptpc_pkg::EPS_RESET;
    end else begin
      pending <= 3'(pending + {2'b00, q_in} - {2'b00, r_out});
      if (cfg_we && cfg_index == ptpc_pkg::CFG_EPSILON) begin
        eps <= cfg_data;
      end
    end
  end

  assign dw        = 55'(rsp_depth);
  assign ew        = signed'({2'b00, eps});
  assign depth_ok  = (dw <= ew) && (dw >= -ew);
  assign miss_zero = (rsp_index == '0) && (rsp_depth == '0) && (rsp_fx == '0)
                     && (rsp_fy == '0) && (rsp_fz == '0);

  `PTPC_ASSERT(a_no_orphan, clk, rst, rsp_valid |-> pending != 3'd0)
  `PTPC_ASSERT(a_hold, clk, rst, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_depth))
  `PTPC_ASSERT(a_miss_zero, clk, rst, rsp_valid && !rsp_hit |-> miss_zero)
  `PTPC_ASSERT(a_hit_depth, clk, rst, rsp_valid && rsp_hit |-> depth_ok)
  `PTPC_ASSERT_ALWAYS(a_reset_empty, clk, $past(rst) |-> !rsp_valid)

endmodule

bind point_triangle_penalty_collision ptpc_checker u_ptpc_checker (
  .clk        (clk),
  .rst        (rst),
  .cfg_we     (cfg_we),
  .cfg_index  (cfg_index),
  .cfg_data   (cfg_data),
  .req_valid  (req.valid),
  .req_ready  (req.ready),
  .req_action (req.action),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .rsp_hit    (rsp.hit),
  .rsp_index  (rsp.triangle_index),
  .rsp_depth  (rsp.depth),
  .rsp_fx     (rsp.force_x),
  .rsp_fy     (rsp.force_y),
  .rsp_fz     (rsp.force_z)
);

`default_nettype wire

>>> bench/point_triangle_penalty_collision_tb.sv
// Self-checking bench for the point-triangle proximity and penalty force block.
`timescale 1ns / 1ps

module point_triangle_penalty_collision_tb;

  typedef logic signed [127:0] wide_t;

  typedef struct packed {
    logic                                act;
    logic [ptpc_pkg::SLOT_W-1:0]         slot;
    logic signed [ptpc_pkg::COORD_W-1:0] x;
    logic signed [ptpc_pkg::COORD_W-1:0] y;
    logic signed [ptpc_pkg::COORD_W-1:0] z;
  } probe_t;

  typedef struct packed {
    logic                                hit;
    logic [ptpc_pkg::IDX_W-1:0]          idx;
    logic signed [ptpc_pkg::DEPTH_W-1:0] depth;
    logic signed [ptpc_pkg::FORCE_W-1:0] fx;
    logic signed [ptpc_pkg::FORCE_W-1:0] fy;
    logic signed [ptpc_pkg::FORCE_W-1:0] fz;
  } contact_t;

  typedef enum logic {STEP_ITEM, STEP_CFG} step_kind_t;

  typedef struct packed {
    step_kind_t                     kind;
    probe_t                         probe;
    logic [ptpc_pkg::CFG_IDX_W-1:0] reg_idx;
    logic [ptpc_pkg::EPS_W-1:0]     reg_val;
    logic                           known;
    contact_t                       known_res;
  } step_t;

  localparam int NUM_SLOTS = 768;
  localparam int FILL_TRIS = 8;
  localparam logic [ptpc_pkg::EPS_W-1:0] EPS_MAX = {ptpc_pkg::EPS_W{1'b1}};

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [ptpc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [ptpc_pkg::EPS_W-1:0] cfg_data = '0;

  ptpc_in_if  req_if ();
  ptpc_out_if rsp_if ();

  point_triangle_penalty_collision dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .req(req_if), .rsp(rsp_if)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Mirror of the block: vertex store and registers
  logic [47:0] vertex_mem [NUM_SLOTS];
  logic [ptpc_pkg::EPS_W-1:0] eps_reg;
  logic [ptpc_pkg::CNT_W-1:0] tri_count_reg;

  contact_t pending_contacts[$];
  int errors = 0;
  int send_idle = 0;
  int recv_idle = 0;

  function automatic void cross3(input wide_t u[3], input wide_t v[3], output wide_t r[3]);
    r[0] = u[1] * v[2] - u[2] * v[1];
    r[1] = u[2] * v[0] - u[0] * v[2];
    r[2] = u[0] * v[1] - u[1] * v[0];
  endfunction

  function automatic wide_t dot3(input wide_t u[3], input wide_t v[3]);
    return u[0] * v[0] + u[1] * v[1] + u[2] * v[2];
  endfunction

  function automatic wide_t corner(input int slot, input int axis);
    return $signed(vertex_mem[slot][16*axis +: 16]);
  endfunction

  // First triangle within epsilon of the point whose projection lies inside it
  function automatic contact_t predict_contact(input probe_t p);
    wide_t a[3], e1[3], e2[3], pa[3], n[3], t[3];
    wide_t d, den, nu, nv, prod, eps;
    wide_t sat_hi, sat_lo;
    int lim;
    contact_t r;
    r = '0;
    eps = {75'b0, eps_reg};
    sat_hi = 128'sh7FFF_FFFF_FFFF_FFFF;
    sat_lo = -sat_hi - 1;
    lim = (tri_count_reg > 256) ? 256 : int'(tri_count_reg);
    for (int tr = 0; tr < lim; tr++) begin
      for (int k = 0; k < 3; k++) begin
        a[k]  = corner(3*tr, k);
        e1[k] = corner(3*tr + 1, k) - a[k];
        e2[k] = corner(3*tr + 2, k) - a[k];
      end
      pa[0] = wide_t'(p.x) - a[0];
      pa[1] = wide_t'(p.y) - a[1];
      pa[2] = wide_t'(p.z) - a[2];
      cross3(e1, e2, n);
      d = dot3(n, pa);
      if (d > eps || d < -eps) continue;
      den = dot3(n, n);
      cross3(e1, pa, t);
      nu = dot3(t, n);
      cross3(pa, e2, t);
      nv = dot3(t, n);
      if (den <= 0 || nu < 0 || nv < 0 || den - nu - nv <= 0) continue;
      r.hit = 1'b1;
      r.idx = tr[ptpc_pkg::IDX_W-1:0];
      r.depth = d[ptpc_pkg::DEPTH_W-1:0];
      for (int k = 0; k < 3; k++) begin
        prod = (eps - d) * n[k];
        if (prod > sat_hi) prod = sat_hi;
        else if (prod < sat_lo) prod = sat_lo;
        if (k == 0) r.fx = prod[63:0];
        else if (k == 1) r.fy = prod[63:0];
        else r.fz = prod[63:0];
      end
      return r;
    end
    return r;
  endfunction

  task automatic report_error(input string what, input contact_t exp_c, input contact_t got);
    errors++;
    if (errors <= 10)
      $display("mismatch %0s: exp hit=%0d tri=%0d depth=%0d f=(%0d,%0d,%0d)",
               what, exp_c.hit, exp_c.idx, exp_c.depth, exp_c.fx, exp_c.fy, exp_c.fz,
               " got hit=%0d tri=%0d depth=%0d f=(%0d,%0d,%0d)",
               got.hit, got.idx, got.depth, got.fx, got.fy, got.fz);
  endtask

  // Result side: random stalls and comparison against the oldest expectation
  always @(posedge clk) begin
    contact_t got, exp_c;
    if (rst) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        got = {rsp_if.hit, rsp_if.triangle_index, rsp_if.depth,
               rsp_if.force_x, rsp_if.force_y, rsp_if.force_z};
        if (pending_contacts.size() == 0) begin
          report_error("unexpected result", '0, got);
        end else begin
          exp_c = pending_contacts.pop_front();
          if (got.hit !== exp_c.hit || got.idx !== exp_c.idx || got.depth !== exp_c.depth ||
              got.fx !== exp_c.fx || got.fy !== exp_c.fy || got.fz !== exp_c.fz)
            report_error("contact", exp_c, got);
        end
      end
      rsp_if.ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // Offer one item; update the mirror when it is accepted
  task automatic push_item(input probe_t p, input logic known, input contact_t known_res);
    while ($urandom_range(99) < send_idle) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid        <= 1'b1;
    req_if.action       <= p.act;
    req_if.vertex_index <= p.slot;
    req_if.coord_x      <= p.x;
    req_if.coord_y      <= p.y;
    req_if.coord_z      <= p.z;
    do @(posedge clk); while (!req_if.ready);
    if (p.act == ptpc_pkg::ACT_LOAD) begin
      if (p.slot < NUM_SLOTS) vertex_mem[p.slot] = {p.z, p.y, p.x};
    end else begin
      pending_contacts.push_back(known ? known_res : predict_contact(p));
    end
  endtask

  // Wait until every expected result is in, then let trailing loads settle
  task automatic drain();
    req_if.valid <= 1'b0;
    while (pending_contacts.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(input logic [ptpc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [ptpc_pkg::EPS_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == ptpc_pkg::CFG_EPSILON) eps_reg = val;
    else tri_count_reg = val[ptpc_pkg::CNT_W-1:0];
    @(posedge clk);
  endtask

  function automatic probe_t mk_probe(input logic act, input int slot,
                                      input int x, input int y, input int z);
    probe_t p;
    p.act = act;
    p.slot = slot[ptpc_pkg::SLOT_W-1:0];
    p.x = x[15:0];
    p.y = y[15:0];
    p.z = z[15:0];
    return p;
  endfunction

  function automatic step_t mk_item(input probe_t p, input logic known, input contact_t res);
    step_t s;
    s = '0;
    s.kind = STEP_ITEM;
    s.probe = p;
    s.known = known;
    s.known_res = res;
    return s;
  endfunction

  function automatic step_t mk_cfg(input logic [ptpc_pkg::CFG_IDX_W-1:0] idx,
                                   input logic [ptpc_pkg::EPS_W-1:0] val);
    step_t s;
    s = '0;
    s.kind = STEP_CFG;
    s.reg_idx = idx;
    s.reg_val = val;
    return s;
  endfunction

  function automatic int srand(input int span);
    return $urandom_range(2*span) - span;
  endfunction

  // Point near a stored triangle: a barycentric blend plus a little jitter
  function automatic probe_t near_point();
    int lim, tr, i, j;
    int v[3];
    lim = (tri_count_reg > 256) ? 256 : int'(tri_count_reg);
    tr = $urandom_range(lim - 1);
    i = $urandom_range(8);
    j = $urandom_range(8 - i);
    for (int k = 0; k < 3; k++)
      v[k] = int'(corner(3*tr, k)) +
             ((int'(corner(3*tr+1, k) - corner(3*tr, k))) * i +
              (int'(corner(3*tr+2, k) - corner(3*tr, k))) * j) / 8 + srand(3);
    return mk_probe(ptpc_pkg::ACT_QUERY, 0, v[0], v[1], v[2]);
  endfunction

  task automatic load_triangle(input int tr);
    int a[3];
    logic flat;
    flat = ($urandom_range(15) == 0);
    for (int k = 0; k < 3; k++) a[k] = srand(1500);
    push_item(mk_probe(ptpc_pkg::ACT_LOAD, 3*tr, a[0], a[1], a[2]), 1'b0, '0);
    push_item(mk_probe(ptpc_pkg::ACT_LOAD, 3*tr+1, a[0]+srand(200), a[1]+srand(200),
                       a[2]+srand(200)), 1'b0, '0);
    if (flat)
      push_item(mk_probe(ptpc_pkg::ACT_LOAD, 3*tr+2, a[0], a[1], a[2]), 1'b0, '0);
    else
      push_item(mk_probe(ptpc_pkg::ACT_LOAD, 3*tr+2, a[0]+srand(200), a[1]+srand(200),
                         a[2]+srand(200)), 1'b0, '0);
  endtask

  task automatic random_item();
    int pick;
    pick = $urandom_range(99);
    if (pick < 70)
      push_item(near_point(), 1'b0, '0);
    else if (pick < 78)
      load_triangle($urandom_range(((tri_count_reg > 256) ? 256 : tri_count_reg) - 1));
    else if (pick < 85)
      push_item(mk_probe(ptpc_pkg::ACT_LOAD, $urandom_range(1023), $urandom, $urandom,
                         $urandom), 1'b0, '0);
    else
      push_item(mk_probe(ptpc_pkg::ACT_QUERY, $urandom_range(1023), $urandom, $urandom,
                         $urandom), 1'b0, '0);
  endtask

  step_t plan[$];

  initial begin
    contact_t miss, c;
    logic [ptpc_pkg::EPS_W-1:0] eps_pick;
    int seg_items;

    eps_reg = ptpc_pkg::EPS_RESET;
    tri_count_reg = '0;
    miss = '0;
    req_if.valid = 1'b0;
    req_if.action = ptpc_pkg::ACT_LOAD;
    req_if.vertex_index = '0;
    req_if.coord_x = '0;
    req_if.coord_y = '0;
    req_if.coord_z = '0;
    rsp_if.ready = 1'b0;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: right triangle of side 1.0 on z=0, a degenerate one, a huge one
    plan.push_back(mk_item(mk_probe(ptpc_pkg::ACT_QUERY, 0, 0, 0, 0), 1'b1, miss));
    plan.push_back(mk_item(mk_probe(ptpc_pkg::ACT_LOAD, 0, 0, 0, 0), 1'b0, '0));
    plan.push_back(mk_item(mk_probe(ptpc_pkg::ACT_LOAD, 1, 16, 0, 0), 1'b0, '0));
    plan.push_back(mk_item(mk_probe(ptpc_pkg::ACT_LOAD, 2, 0, 16, 0), 1'b0, '0));
    for (int k = 3; k < 6; k++)
      plan.push_back(mk_item(mk_probe(ptpc_pkg::ACT_LOAD, k, 32, 32, 32), 1'b0, '0));
    plan.push_back(mk_item(mk_probe(ptpc_pkg::ACT_LOAD, 768, -32768, -32768, -32768),
                           1'b0, '0));
    plan.push_back(mk_item(mk_probe(ptpc_pkg::ACT_LOAD, 1023, 32767, 32767, 32767),
                           1'b0, '0));
    plan.push_back(mk_cfg(ptpc_pkg::CFG_TRI_COUNT, 53'd2));
    c = '0;
    c.hit = 1'b1;
    c.fz = 64'sd5242880;
    plan.push_back(mk_item(mk_probe(ptpc_pkg::ACT_QUERY, 0, 4, 4, 0), 1'b1, c));
    plan.push_back(mk_item(mk_probe(ptpc_pkg::ACT_QUERY, 0, 4, 4, 16), 1'b0, '0));
    plan.push_back(mk_item(mk_probe(ptpc_pkg::ACT_QUERY, 0, 4, 4, 100), 1'b1, miss));
    plan.push_back(mk_item(mk_probe(ptpc_pkg::ACT_QUERY, 0, 20, 20, 0), 1'b1, miss));
    plan.push_back(mk_item(mk_probe(ptpc_pkg::ACT_LOAD, 6, -32768, -32768, 0), 1'b0, '0));
    plan.push_back(mk_item(mk_probe(ptpc_pkg::ACT_LOAD, 7, 32767, -32768, 0), 1'b0, '0));
    plan.push_back(mk_item(mk_probe(ptpc_pkg::ACT_LOAD, 8, -32768, 32767, 0), 1'b0, '0));
    plan.push_back(mk_cfg(ptpc_pkg::CFG_TRI_COUNT, 53'd3));
    plan.push_back(mk_cfg(ptpc_pkg::CFG_EPSILON, EPS_MAX));
    plan.push_back(mk_item(mk_probe(ptpc_pkg::ACT_QUERY, 0, 100, 100, -32768), 1'b0, '0));
    plan.push_back(mk_item(mk_probe(ptpc_pkg::ACT_QUERY, 0, 100, 100, 32767), 1'b0, '0));
    plan.push_back(mk_item(mk_probe(ptpc_pkg::ACT_QUERY, 0, -32768, -32768, -32768),
                           1'b0, '0));
    plan.push_back(mk_cfg(ptpc_pkg::CFG_EPSILON, 53'd0));
    plan.push_back(mk_item(mk_probe(ptpc_pkg::ACT_QUERY, 0, 4, 4, 0), 1'b0, '0));
    plan.push_back(mk_item(mk_probe(ptpc_pkg::ACT_QUERY, 0, 32767, 32767, 32767),
                           1'b0, '0));

    foreach (plan[s]) begin
      if (plan[s].kind == STEP_CFG) begin
        drain();
        write_reg(plan[s].reg_idx, plan[s].reg_val);
      end else begin
        push_item(plan[s].probe, plan[s].known, plan[s].known_res);
      end
    end

    // Load every triangle that the random counts can scan
    for (int tr = 0; tr < FILL_TRIS; tr++) load_triangle(tr);

    // Random part: three idling modes, three register settings each
    for (int mode = 0; mode < 3; mode++) begin
      send_idle = (mode == 0) ? 26 : (mode == 1) ? 52 : 0;
      recv_idle = (mode == 0) ? 52 : (mode == 1) ? 26 : 0;
      for (int seg = 0; seg < 3; seg++) begin
        drain();
        case ($urandom_range(5))
          0: eps_pick = '0;
          1: eps_pick = EPS_MAX;
          default: eps_pick = ptpc_pkg::EPS_W'($urandom) >> $urandom_range(31);
        endcase
        write_reg(ptpc_pkg::CFG_EPSILON, eps_pick);
        seg_items = 50;
        write_reg(ptpc_pkg::CFG_TRI_COUNT, 53'd1 + $urandom_range(FILL_TRIS - 1));
        for (int n = 0; n < seg_items; n++) random_item();
      end
    end

    drain();
    if (errors == 0 && pending_contacts.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #(64'd40_000_000);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
